[rtl/cnlc_pkg.sv]
// shared types and constants of the card number luhn classifier
package cnlc_pkg;

    // a positive signed 64-bit number has 63 magnitude bits and at most 19 digits
    localparam int BIN_W      = 63;
    localparam int NUM_DIGITS = 19;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int IDX_W      = $clog2(NUM_DIGITS + 1);
    localparam int SHIFT_W    = $clog2(BIN_W);

    // length rules
    localparam logic [IDX_W-1:0] LEN_3X     = IDX_W'(15);
    localparam logic [IDX_W-1:0] LEN_5X     = IDX_W'(16);
    localparam logic [IDX_W-1:0] LEN_4X_MIN = IDX_W'(13);
    localparam logic [IDX_W-1:0] LEN_4X_MAX = IDX_W'(16);

    // prefix digits: 34/37, 51..55, 40..49
    localparam logic [3:0] PFX_3X_HI  = 4'd3;
    localparam logic [3:0] PFX_3X_LOA = 4'd4;
    localparam logic [3:0] PFX_3X_LOB = 4'd7;
    localparam logic [3:0] PFX_5X_HI  = 4'd5;
    localparam logic [3:0] PFX_5X_MIN = 4'd1;
    localparam logic [3:0] PFX_5X_MAX = 4'd5;
    localparam logic [3:0] PFX_4X_HI  = 4'd4;

    typedef enum logic [1:0] {
        CT_INVALID   = 2'd0,
        CT_PREFIX_3X = 2'd1,
        CT_PREFIX_5X = 2'd2,
        CT_PREFIX_4X = 2'd3
    } t_card_type;

endpackage

[rtl/cnlc_bcd_conv.sv]
// iterative binary to bcd converter, one magnitude bit per cycle (shift and add 3)
module cnlc_bcd_conv (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [cnlc_pkg::BIN_W-1:0]      i_bin,
    output logic                            o_done,
    output logic [cnlc_pkg::BCD_W-1:0]      o_bcd
);

    logic [cnlc_pkg::BCD_W-1:0]   r_bcd, n_bcd;
    logic [cnlc_pkg::BIN_W-1:0]   r_bin, n_bin;
    logic [cnlc_pkg::SHIFT_W-1:0] r_cnt;
    logic                         r_run;
    logic                         r_done;
    logic [cnlc_pkg::BCD_W-1:0]   adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int k = 0; k < cnlc_pkg::NUM_DIGITS; k++) begin
            dig = r_bcd[4*k +: 4];
            adj[4*k +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
        n_bcd = {adj[cnlc_pkg::BCD_W-2:0], r_bin[cnlc_pkg::BIN_W-1]};
        n_bin = {r_bin[cnlc_pkg::BIN_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cnlc_pkg::SHIFT_W'(cnlc_pkg::BIN_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bcd <= '0;
            r_bin <= i_bin;
        end else if (r_run) begin
            r_bcd <= n_bcd;
            r_bin <= n_bin;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

[rtl/card_number_luhn_classifier.sv]
// card number classifier: luhn mod 10 check plus prefix and length rules
// sequence: from accept to the o_valid strobe a positive number passes through
//   bit-serial bcd conversion, a digit scan and the result handoff; a zero or
//   negative number skips conversion and scan and goes straight to the result
// throughput: one item at a time, busy stays high until the result strobe
// reset: synchronous active-low i_rst_n returns the sequencer to idle;
//   the result is a one-cycle strobe that the receiver cannot stall
module card_number_luhn_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [63:0] i_card_number,
    output logic               o_valid,
    output logic [1:0]         o_card_type
);

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic                               accept;
    logic                               bad_num;
    logic                               conv_done;
    logic [cnlc_pkg::BCD_W-1:0]         conv_bcd;

    // digit scan registers
    logic [cnlc_pkg::BCD_W-1:0]         r_digits;
    logic [cnlc_pkg::IDX_W-1:0]         r_idx;
    logic [cnlc_pkg::IDX_W-1:0]         r_len;
    logic [3:0]                         r_sum;
    logic [3:0]                         r_prev;
    logic [3:0]                         r_lead_hi;
    logic [3:0]                         r_lead_lo;
    logic                               r_bad;

    logic                               r_valid;
    cnlc_pkg::t_card_type               r_type;

    // current digit and its luhn contribution
    logic [3:0]                         dig;
    logic [4:0]                         dbl;
    logic [3:0]                         contrib;
    logic [4:0]                         sum_raw;
    logic [3:0]                         n_sum;
    cnlc_pkg::t_card_type               n_type;

    assign accept  = start && r_state == S_IDLE;
    // zero or sign bit set is rejected without conversion
    assign bad_num = i_card_number[63] || i_card_number == 64'sd0;

    cnlc_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && !bad_num),
        .i_bin   (i_card_number[cnlc_pkg::BIN_W-1:0]),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    // luhn: every second digit, from the second rightmost on, is doubled, a product
    // above 9 loses 9; the sum is kept modulo 10 as it accumulates
    always_comb begin
        dig     = r_digits[3:0];
        dbl     = {dig, 1'b0};
        if (r_idx[0]) begin
            contrib = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
        end else begin
            contrib = dig;
        end
        sum_raw = {1'b0, r_sum} + {1'b0, contrib};
        n_sum   = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
    end

    // classification in priority order once the scan is over
    always_comb begin
        n_type = cnlc_pkg::CT_INVALID;
        priority if (r_bad || r_sum != 4'd0) begin
            n_type = cnlc_pkg::CT_INVALID;
        end else if (r_lead_hi == cnlc_pkg::PFX_3X_HI
                     && (r_lead_lo == cnlc_pkg::PFX_3X_LOA
                         || r_lead_lo == cnlc_pkg::PFX_3X_LOB)
                     && r_len == cnlc_pkg::LEN_3X) begin
            n_type = cnlc_pkg::CT_PREFIX_3X;
        end else if (r_lead_hi == cnlc_pkg::PFX_5X_HI
                     && r_lead_lo >= cnlc_pkg::PFX_5X_MIN
                     && r_lead_lo <= cnlc_pkg::PFX_5X_MAX
                     && r_len == cnlc_pkg::LEN_5X) begin
            n_type = cnlc_pkg::CT_PREFIX_5X;
        end else if (r_lead_hi == cnlc_pkg::PFX_4X_HI
                     && r_len >= cnlc_pkg::LEN_4X_MIN
                     && r_len <= cnlc_pkg::LEN_4X_MAX) begin
            n_type = cnlc_pkg::CT_PREFIX_4X;
        end else begin
            n_type = cnlc_pkg::CT_INVALID;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = bad_num ? S_DONE : S_CONV;
                end
            end
            S_CONV: begin
                if (conv_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == cnlc_pkg::IDX_W'(cnlc_pkg::NUM_DIGITS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= r_state == S_DONE;
        end
    end

    // datapath: load digits, then walk them from the least significant end
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bad <= bad_num;
        end
        if (r_state == S_CONV && conv_done) begin
            r_digits  <= conv_bcd;
            r_idx     <= '0;
            r_len     <= '0;
            r_sum     <= 4'd0;
            r_prev    <= 4'd0;
            r_lead_hi <= 4'd0;
            r_lead_lo <= 4'd0;
        end else if (r_state == S_SCAN) begin
            r_digits <= r_digits >> 4;
            r_idx    <= r_idx + 1'b1;
            r_sum    <= n_sum;
            r_prev   <= dig;
            // highest nonzero digit so far sets length and leading pair
            if (dig != 4'd0) begin
                r_len     <= r_idx + 1'b1;
                r_lead_hi <= dig;
                r_lead_lo <= r_prev;
            end
        end
        if (r_state == S_DONE) begin
            r_type <= n_type;
        end
    end

    assign busy        = r_state != S_IDLE;
    assign o_valid     = r_valid;
    assign o_card_type = r_type;

endmodule
